/* design/pfx_pkg.sv */
//------------------------------------------------------------------------------
// pfx_pkg
// Shared types and constants of the pixel fade and border effect unit.
//------------------------------------------------------------------------------
package pfx_pkg;

    localparam int NCH         = 3;
    localparam int ROW_W       = 9;
    localparam int PIX_W       = 32;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 32;
    localparam int SCREEN_ROWS = 480;
    localparam int ROW_CMP_W   = 13;

    localparam logic [ROW_W-1:0] BORDER_BOTTOM_RST = ROW_W'(SCREEN_ROWS);

    localparam logic [2:0] FADE_NONE  = 3'd0;
    localparam logic [2:0] FADE_ADD   = 3'd1;
    localparam logic [2:0] FADE_SUB   = 3'd2;
    localparam logic [2:0] FADE_BLEND = 3'd3;
    localparam logic [2:0] FADE_FILL  = 3'd4;

    localparam logic [1:0] BORDER_FILL   = 2'd0;
    localparam logic [1:0] BORDER_BLEND1 = 2'd1;
    localparam logic [1:0] BORDER_BLEND2 = 2'd2;
    localparam logic [1:0] BORDER_OFF    = 2'd3;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FADE_MODE        = 3'd0,
        REG_FADE_ALPHA       = 3'd1,
        REG_FADE_FROM_COLOUR = 3'd2,
        REG_FADE_TO_COLOUR   = 3'd3,
        REG_BORDER_MODE      = 3'd4,
        REG_BORDER_COLOUR    = 3'd5,
        REG_BORDER_TOP       = 3'd6,
        REG_BORDER_BOTTOM    = 3'd7
    } cfg_idx_t;

    typedef struct packed {
        logic [2:0]       fade_mode;
        logic [7:0]       fade_alpha;
        logic [23:0]      fade_from_colour;
        logic [23:0]      fade_to_colour;
        logic [1:0]       border_mode;
        logic [31:0]      border_colour;
        logic [ROW_W-1:0] border_top;
        logic [ROW_W-1:0] border_bottom;
    } cfg_t;

    // fade stage result handed to the border stage
    typedef struct packed {
        logic [PIX_W-1:0] pixel;
        logic             skip_border;
        logic             in_band;
    } fade_res_t;

endpackage

/* design/pfx_if.sv */
//------------------------------------------------------------------------------
// pfx_if
// Valid/ready stream interfaces for pixel input and pixel output.
//------------------------------------------------------------------------------
interface pfx_in_if
    import pfx_pkg::*;
;
    logic             valid;
    logic             ready;
    logic [ROW_W-1:0] row;
    logic [PIX_W-1:0] pixel_in;

    modport source (output valid, output row, output pixel_in, input ready);
    modport sink   (input valid, input row, input pixel_in, output ready);
endinterface

interface pfx_out_if
    import pfx_pkg::*;
;
    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] pixel_out;

    modport source (output valid, output pixel_out, input ready);
    modport sink   (input valid, input pixel_out, output ready);
endinterface

/* design/pfx_fade.sv */
//------------------------------------------------------------------------------
// pfx_fade
// Fade stages: channel products, then lerp, saturating add/sub, blend and fill.
//------------------------------------------------------------------------------
module pfx_fade
    import pfx_pkg::*;
#(
    parameter int ROWS = SCREEN_ROWS
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  cfg_t             cfg,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [ROW_W-1:0] row,
    input  logic [PIX_W-1:0] pixel,
    output logic             out_valid,
    input  logic             out_ready,
    output fade_res_t        out_data
);

    typedef enum logic [2:0] {
        OP_PASS,
        OP_ADD,
        OP_SUB,
        OP_BLEND,
        OP_FILL
    } op_t;

    localparam logic [ROW_CMP_W-1:0] ROWS_LIM = ROW_CMP_W'(ROWS);

    // stage 1 registers
    logic             v1_reg;
    op_t              op1_reg;
    logic             band1_reg;
    logic [PIX_W-1:0] px1_reg;
    logic             ge1_reg   [NCH];
    logic [7:0]       f1_reg    [NCH];
    logic [15:0]      prod1_reg [NCH];
    logic [15:0]      pk1_reg   [NCH];
    logic [15:0]      wf1_reg   [NCH];
    logic [15:0]      wt1_reg   [NCH];

    // stage 2 registers
    logic             v2_reg;
    fade_res_t        res2_reg;

    logic             en1;
    logic             en2;
    logic [7:0]       k_c;
    op_t              op_c;
    logic             band_c;
    logic             ge_c   [NCH];
    logic [7:0]       f_c    [NCH];
    logic [7:0]       t_c    [NCH];
    logic [7:0]       p_c    [NCH];
    logic [7:0]       d_c    [NCH];
    logic [15:0]      prod_c [NCH];
    logic [15:0]      pk_c   [NCH];
    logic [15:0]      wf_c   [NCH];
    logic [15:0]      wt_c   [NCH];
    fade_res_t        res2_next;

    assign en2      = !v2_reg || out_ready;
    assign en1      = !v1_reg || en2;
    assign in_ready = en1;

    always_comb
    begin
        k_c = 8'hFF - cfg.fade_alpha;
        if (cfg.fade_alpha != 8'd0 && cfg.fade_mode == FADE_ADD)
        begin
            op_c = OP_ADD;
        end
        else if (cfg.fade_alpha != 8'd0 && cfg.fade_mode == FADE_SUB)
        begin
            op_c = OP_SUB;
        end
        else if (cfg.fade_alpha != 8'd0 && cfg.fade_mode == FADE_BLEND)
        begin
            op_c = OP_BLEND;
        end
        else if (cfg.fade_mode == FADE_FILL)
        begin
            op_c = OP_FILL;
        end
        else
        begin
            op_c = OP_PASS;
        end
        band_c = (ROW_CMP_W'(row) < ROWS_LIM) &&
                 (row < cfg.border_top || row >= cfg.border_bottom);
        for (int i = 0; i < NCH; i++)
        begin
            f_c[i]    = cfg.fade_from_colour[8*i +: 8];
            t_c[i]    = cfg.fade_to_colour[8*i +: 8];
            p_c[i]    = pixel[8*i +: 8];
            ge_c[i]   = t_c[i] >= f_c[i];
            d_c[i]    = ge_c[i] ? (t_c[i] - f_c[i]) : (f_c[i] - t_c[i]);
            prod_c[i] = 16'(cfg.fade_alpha) * 16'(d_c[i]);
            pk_c[i]   = 16'(p_c[i]) * 16'(k_c);
            wf_c[i]   = 16'(k_c) * 16'(f_c[i]);
            wt_c[i]   = 16'(cfg.fade_alpha) * 16'(t_c[i]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
        end
        else if (en1)
        begin
            v1_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en1 && in_valid)
        begin
            op1_reg   <= op_c;
            band1_reg <= band_c;
            px1_reg   <= pixel;
            for (int i = 0; i < NCH; i++)
            begin
                ge1_reg[i]   <= ge_c[i];
                f1_reg[i]    <= f_c[i];
                prod1_reg[i] <= prod_c[i];
                pk1_reg[i]   <= pk_c[i];
                wf1_reg[i]   <= wf_c[i];
                wt1_reg[i]   <= wt_c[i];
            end
        end
    end

    // per channel lerp, saturate and blend
    always_comb
    begin
        logic [7:0]  p;
        logic [7:0]  c256;
        logic [7:0]  q255;
        logic [7:0]  c255;
        logic [8:0]  asum;
        logic [17:0] bsum;
        logic [7:0]  ch;
        res2_next             = '0;
        res2_next.skip_border = (op1_reg == OP_BLEND);
        res2_next.in_band     = band1_reg;
        res2_next.pixel[31:24] = (op1_reg == OP_FILL) ? 8'h00 : px1_reg[31:24];
        for (int i = 0; i < NCH; i++)
        begin
            p    = px1_reg[8*i +: 8];
            c256 = ge1_reg[i] ? (f1_reg[i] + prod1_reg[i][15:8])
                              : (f1_reg[i] - 8'((17'(prod1_reg[i]) + 17'd255) >> 8));
            q255 = 8'((17'(prod1_reg[i]) + 17'(prod1_reg[i][15:8]) + 17'd1) >> 8);
            c255 = ge1_reg[i] ? (f1_reg[i] + q255) : (f1_reg[i] - q255);
            asum = 9'(p) + 9'(c256);
            bsum = 18'(pk1_reg[i]) + 18'(wf1_reg[i]) + 18'(wt1_reg[i]);
            case (op1_reg)
                OP_ADD:   ch = asum[8] ? 8'hFF : asum[7:0];
                OP_SUB:   ch = (p > c256) ? (p - c256) : 8'h00;
                OP_BLEND: ch = (bsum > 18'd65535) ? 8'hFF : bsum[15:8];
                OP_FILL:  ch = c255;
                default:  ch = p;
            endcase
            res2_next.pixel[8*i +: 8] = ch;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg <= 1'b0;
        end
        else if (en2)
        begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en2 && v1_reg)
        begin
            res2_reg <= res2_next;
        end
    end

    assign out_valid = v2_reg;
    assign out_data  = res2_reg;

endmodule

/* design/pfx_border.sv */
//------------------------------------------------------------------------------
// pfx_border
// Border stages: blend products, then fill/blend select into output register.
//------------------------------------------------------------------------------
module pfx_border
    import pfx_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  cfg_t             cfg,
    input  logic             in_valid,
    output logic             in_ready,
    input  fade_res_t        in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [PIX_W-1:0] pixel_out
);

    typedef enum logic [1:0] {
        ACT_PASS,
        ACT_FILL,
        ACT_BLEND
    } act_t;

    logic             v3_reg;
    act_t             act3_reg;
    logic [PIX_W-1:0] px3_reg;
    logic [15:0]      pk3_reg [NCH];
    logic [15:0]      ab3_reg [NCH];

    logic             v4_reg;
    logic [PIX_W-1:0] px4_reg;

    logic             en3;
    logic             en4;
    logic [7:0]       ba_c;
    logic [7:0]       kb_c;
    act_t             act_c;
    logic             blend_ok;
    logic [15:0]      pk_c [NCH];
    logic [15:0]      ab_c [NCH];
    logic [PIX_W-1:0] px4_next;

    assign en4      = !v4_reg || out_ready;
    assign en3      = !v3_reg || en4;
    assign in_ready = en3;

    always_comb
    begin
        ba_c     = cfg.border_colour[31:24];
        kb_c     = 8'hFF - ba_c;
        blend_ok = (cfg.border_mode inside {BORDER_BLEND1, BORDER_BLEND2}) &&
                   (cfg.border_top != '0);
        if (in_data.skip_border || !in_data.in_band)
        begin
            act_c = ACT_PASS;
        end
        else if (cfg.border_mode == BORDER_FILL)
        begin
            act_c = ACT_FILL;
        end
        else if (blend_ok)
        begin
            act_c = ACT_BLEND;
        end
        else
        begin
            act_c = ACT_PASS;
        end
        for (int i = 0; i < NCH; i++)
        begin
            pk_c[i] = 16'(in_data.pixel[8*i +: 8]) * 16'(kb_c);
            ab_c[i] = 16'(ba_c) * 16'(cfg.border_colour[8*i +: 8]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v3_reg <= 1'b0;
        end
        else if (en3)
        begin
            v3_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en3 && in_valid)
        begin
            act3_reg <= act_c;
            px3_reg  <= in_data.pixel;
            for (int i = 0; i < NCH; i++)
            begin
                pk3_reg[i] <= pk_c[i];
                ab3_reg[i] <= ab_c[i];
            end
        end
    end

    always_comb
    begin
        logic [16:0] s;
        case (act3_reg)
            ACT_FILL:
            begin
                px4_next = {8'h00, cfg.border_colour[23:0]};
            end
            ACT_BLEND:
            begin
                px4_next = px3_reg;
                for (int i = 0; i < NCH; i++)
                begin
                    s = 17'(pk3_reg[i]) + 17'(ab3_reg[i]);
                    px4_next[8*i +: 8] = s[16] ? 8'hFF : s[15:8];
                end
            end
            default:
            begin
                px4_next = px3_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v4_reg <= 1'b0;
        end
        else if (en4)
        begin
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en4 && v3_reg)
        begin
            px4_reg <= px4_next;
        end
    end

    assign out_valid = v4_reg;
    assign pixel_out = px4_reg;

endmodule

/* design/pixel_fade_and_border_effects.sv */
//------------------------------------------------------------------------------
// pixel_fade_and_border_effects
// Per-pixel fade and top/bottom border effect unit, one pixel per clock when unstalled.
//------------------------------------------------------------------------------
// Takes one pixel per clock, while the output is not stalled, into a
// four-stage pipeline: fade products, fade lerp/saturate/blend, border
// products, border blend/fill into the output register. Each stage holds
// independently, so bubbles are squeezed out while the output is stalled and
// the input keeps taking pixels until every stage is full. Users must write
// cfg registers only with no pixel in flight; the block does not enforce it.
module pixel_fade_and_border_effects
    import pfx_pkg::*;
#(
    parameter int ROWS = SCREEN_ROWS
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    pfx_in_if.sink                pix_in,
    pfx_out_if.source             pix_out,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    cfg_t      cfg_reg;
    logic      fade_valid;
    logic      border_ready;
    fade_res_t fade_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '{border_bottom: BORDER_BOTTOM_RST, default: '0};
        end
        else if (cfg_we)
        begin
            case (cfg_idx_t'(cfg_index))
                REG_FADE_MODE:        cfg_reg.fade_mode        <= cfg_data[2:0];
                REG_FADE_ALPHA:       cfg_reg.fade_alpha       <= cfg_data[7:0];
                REG_FADE_FROM_COLOUR: cfg_reg.fade_from_colour <= cfg_data[23:0];
                REG_FADE_TO_COLOUR:   cfg_reg.fade_to_colour   <= cfg_data[23:0];
                REG_BORDER_MODE:      cfg_reg.border_mode      <= cfg_data[1:0];
                REG_BORDER_COLOUR:    cfg_reg.border_colour    <= cfg_data;
                REG_BORDER_TOP:       cfg_reg.border_top       <= cfg_data[ROW_W-1:0];
                REG_BORDER_BOTTOM:    cfg_reg.border_bottom    <= cfg_data[ROW_W-1:0];
                default:              cfg_reg                  <= cfg_reg;
            endcase
        end
    end

    pfx_fade #(
        .ROWS (ROWS)
    ) u_fade (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .in_valid  (pix_in.valid),
        .in_ready  (pix_in.ready),
        .row       (pix_in.row),
        .pixel     (pix_in.pixel_in),
        .out_valid (fade_valid),
        .out_ready (border_ready),
        .out_data  (fade_data)
    );

    pfx_border u_border (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .in_valid  (fade_valid),
        .in_ready  (border_ready),
        .in_data   (fade_data),
        .out_valid (pix_out.valid),
        .out_ready (pix_out.ready),
        .pixel_out (pix_out.pixel_out)
    );

`ifndef SYNTHESIS
    // a ready sink downstream frees every stage
    a_ready_chain: assert property (@(posedge clk) disable iff (!rst_n)
        pix_out.ready |-> pix_in.ready)
        else $error("input not ready while output is ready");

    // an accepted pixel reaches the output when the output is not stalled
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (pix_in.valid && pix_in.ready) ##1 pix_out.ready ##1 pix_out.ready
            ##1 pix_out.ready |=> pix_out.valid)
        else $error("transaction did not reach the output in time");

    // reset empties the pipeline
    a_reset_empty: assert property (@(posedge clk)
        !rst_n |-> !pix_out.valid && !fade_valid)
        else $error("pipeline holds data during reset");
`endif

endmodule

/* bench/pixel_fade_and_border_effects_test.sv */
//------------------------------------------------------------------------------
// pixel_fade_and_border_effects_test
// Self-checking bench for the per-pixel fade and border effect unit. A local
// predictor tracks the eight registers and works out each processed pixel;
// directed pixels hit the fade modes, border bands and corner cases, then
// random register settings carry random pixel streams under random stalls.
//------------------------------------------------------------------------------
module pixel_fade_and_border_effects_test
    import pfx_pkg::*;
;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int IDLE_LIMIT    = 2000;
    localparam int GAP_PERCENT   = 28;
    localparam int RANDOM_PHASES = 15;
    localparam int PHASE_PIXELS  = 100;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    pfx_in_if  pix_in_bus ();
    pfx_out_if pix_out_bus ();

    // local copy of the register file
    logic [2:0]       cur_fade_mode;
    logic [7:0]       cur_fade_alpha;
    logic [23:0]      cur_fade_from;
    logic [23:0]      cur_fade_to;
    logic [1:0]       cur_border_mode;
    logic [31:0]      cur_border_colour;
    logic [ROW_W-1:0] cur_border_top;
    logic [ROW_W-1:0] cur_border_bottom;

    logic [PIX_W-1:0] expected_pixels[$];
    logic [PIX_W-1:0] wanted_pixel;
    logic             gaps_enabled;
    int               errors = 0;
    int               pixels_sent;
    int               pixels_checked = 0;
    int               settings_used;
    int               idle_cycles = 0;

    pixel_fade_and_border_effects u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .pix_in    (pix_in_bus),
        .pix_out   (pix_out_bus),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #4 clk = ~clk;

    function automatic int unsigned blend_channel(int unsigned p, int unsigned k,
                                                  int unsigned w);
        int unsigned s;
        s = p * k + w;
        if (s > 65535)
            s = 65535;
        return s >> 8;
    endfunction

    function automatic logic [PIX_W-1:0] faded_pixel(logic [ROW_W-1:0] row,
                                                     logic [PIX_W-1:0] px);
        int unsigned      a;
        int unsigned      k;
        int unsigned      f;
        int unsigned      t;
        int unsigned      p;
        int unsigned      c;
        int unsigned      ba;
        int               i;
        logic [PIX_W-1:0] res;
        logic             in_band;
        a = 32'(cur_fade_alpha);
        k = 255 - a;
        if (a != 0 && (cur_fade_mode == FADE_ADD || cur_fade_mode == FADE_SUB))
        begin
            res = {px[31:24], 24'h0};
            for (i = 0; i < NCH; i++)
            begin
                f = 32'(cur_fade_from[8*i +: 8]);
                t = 32'(cur_fade_to[8*i +: 8]);
                p = 32'(px[8*i +: 8]);
                if (t >= f)
                    c = f + ((a * (t - f)) >> 8);
                else
                    c = f - ((a * (f - t) + 255) >> 8);
                if (cur_fade_mode == FADE_ADD)
                    p = (p + c > 255) ? 255 : p + c;
                else
                    p = (p > c) ? p - c : 0;
                res[8*i +: 8] = 8'(p);
            end
            px = res;
        end
        else if (a != 0 && cur_fade_mode == FADE_BLEND)
        begin
            // active blend bypasses the border stage
            res = {px[31:24], 24'h0};
            for (i = 0; i < NCH; i++)
            begin
                f = 32'(cur_fade_from[8*i +: 8]);
                t = 32'(cur_fade_to[8*i +: 8]);
                res[8*i +: 8] = 8'(blend_channel(32'(px[8*i +: 8]), k, k * f + a * t));
            end
            return res;
        end

        if (cur_fade_mode == FADE_FILL)
        begin
            res = '0;
            for (i = 0; i < NCH; i++)
            begin
                f = 32'(cur_fade_from[8*i +: 8]);
                t = 32'(cur_fade_to[8*i +: 8]);
                if (t >= f)
                    c = f + ((t - f) * a) / 255;
                else
                    c = f - ((f - t) * a) / 255;
                res[8*i +: 8] = 8'(c);
            end
            px = res;
        end

        in_band = (row < SCREEN_ROWS) &&
                  (row < cur_border_top || row >= cur_border_bottom);
        if (in_band)
        begin
            if (cur_border_mode == BORDER_FILL)
                px = {8'h0, cur_border_colour[23:0]};
            else if ((cur_border_mode == BORDER_BLEND1 || cur_border_mode == BORDER_BLEND2)
                     && cur_border_top != 0)
            begin
                ba = 32'(cur_border_colour[31:24]);
                for (i = 0; i < NCH; i++)
                    px[8*i +: 8] = 8'(blend_channel(32'(px[8*i +: 8]), 255 - ba,
                                                    ba * 32'(cur_border_colour[8*i +: 8])));
            end
        end
        return px;
    endfunction

    // output handshake: random stalls
    always @(negedge clk)
        pix_out_bus.ready = !gaps_enabled || ($urandom_range(0, 99) >= GAP_PERCENT);

    // result check
    always @(posedge clk)
    begin
        if (rst_n && pix_out_bus.valid && pix_out_bus.ready)
        begin
            pixels_checked++;
            if (expected_pixels.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected pixel, expected none, actual %h",
                         $time, pix_out_bus.pixel_out);
            end
            else
            begin
                wanted_pixel = expected_pixels.pop_front();
                if (pix_out_bus.pixel_out !== wanted_pixel)
                begin
                    errors++;
                    $display("%0t: pixel_out mismatch, expected %h, actual %h",
                             $time, wanted_pixel, pix_out_bus.pixel_out);
                end
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        if (!rst_n || cfg_we || (pix_in_bus.valid && pix_in_bus.ready) ||
            (pix_out_bus.valid && pix_out_bus.ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("%0t: no transaction for %0d cycles", $time, IDLE_LIMIT);
            $display("[pixel_fade_and_border_effects] ERROR");
            $finish;
        end
    end

    task automatic send_pixel(logic [ROW_W-1:0] row, logic [PIX_W-1:0] px);
        while (gaps_enabled && $urandom_range(0, 99) < GAP_PERCENT)
        begin
            @(negedge clk);
            pix_in_bus.valid = 1'b0;
            @(posedge clk);
        end
        @(negedge clk);
        pix_in_bus.valid    = 1'b1;
        pix_in_bus.row      = row;
        pix_in_bus.pixel_in = px;
        @(posedge clk);
        while (!pix_in_bus.ready)
            @(posedge clk);
        expected_pixels.push_back(faded_pixel(row, px));
        pixels_sent++;
    endtask

    task automatic wait_idle(int settle);
        @(negedge clk);
        pix_in_bus.valid = 1'b0;
        while (expected_pixels.size() != 0)
            @(posedge clk);
        repeat (settle) @(posedge clk);
    endtask

    task automatic set_reg(cfg_idx_t idx, logic [31:0] value);
        wait_idle(8);
        @(negedge clk);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = value;
        @(negedge clk);
        cfg_we = 1'b0;
        case (idx)
            REG_FADE_MODE:        cur_fade_mode     = value[2:0];
            REG_FADE_ALPHA:       cur_fade_alpha    = value[7:0];
            REG_FADE_FROM_COLOUR: cur_fade_from     = value[23:0];
            REG_FADE_TO_COLOUR:   cur_fade_to       = value[23:0];
            REG_BORDER_MODE:      cur_border_mode   = value[1:0];
            REG_BORDER_COLOUR:    cur_border_colour = value;
            REG_BORDER_TOP:       cur_border_top    = value[ROW_W-1:0];
            REG_BORDER_BOTTOM:    cur_border_bottom = value[ROW_W-1:0];
            default: ;
        endcase
    endtask

    // random junk above the register width
    function automatic logic [31:0] with_noise(logic [31:0] value, int width);
        logic [31:0] noise;
        noise = $urandom();
        if (width >= 32)
            return value;
        return (noise << width) | value;
    endfunction

    function automatic logic [ROW_W-1:0] pick_row();
        int sel;
        int r;
        sel = $urandom_range(0, 99);
        if (sel < 10)
            r = $urandom_range(SCREEN_ROWS, 511);
        else if (sel < 25)
            r = int'(cur_border_top) + $urandom_range(0, 4) - 2;
        else if (sel < 40)
            r = int'(cur_border_bottom) + $urandom_range(0, 4) - 2;
        else
            r = $urandom_range(0, SCREEN_ROWS - 1);
        return ROW_W'(r);
    endfunction

    task automatic test_reset_state();
        send_pixel(9'd0, 32'hFFFF_FFFF);
        send_pixel(9'd479, 32'h1234_5678);
        send_pixel(9'd511, 32'h0000_0000);
    endtask

    task automatic test_fade_modes();
        int m;
        set_reg(REG_BORDER_MODE, 32'(BORDER_OFF));
        set_reg(REG_FADE_FROM_COLOUR, 32'h10E080);
        set_reg(REG_FADE_TO_COLOUR, 32'hF02000);
        set_reg(REG_FADE_ALPHA, 32'd255);
        for (m = 0; m < 8; m++)
        begin
            set_reg(REG_FADE_MODE, 32'(m));
            send_pixel(9'(m * 60), 32'h80FF_0040 ^ 32'(m * 32'h0101_0101));
        end
        // zero alpha: fill still applies, add does nothing
        set_reg(REG_FADE_ALPHA, 32'd0);
        set_reg(REG_FADE_MODE, 32'(FADE_FILL));
        send_pixel(9'd100, 32'hA5A5_A5A5);
        set_reg(REG_FADE_MODE, 32'(FADE_ADD));
        send_pixel(9'd100, 32'h5A5A_5A5A);
        settings_used++;
    endtask

    task automatic test_border_bands();
        set_reg(REG_BORDER_COLOUR, 32'hC033_6699);
        set_reg(REG_BORDER_TOP, 32'd10);
        set_reg(REG_BORDER_BOTTOM, 32'd470);
        set_reg(REG_BORDER_MODE, 32'(BORDER_FILL));
        set_reg(REG_FADE_ALPHA, 32'd128);
        set_reg(REG_FADE_MODE, 32'(FADE_BLEND));
        send_pixel(9'd5, 32'hDEAD_BEEF);
        set_reg(REG_FADE_MODE, 32'(FADE_NONE));
        send_pixel(9'd9, 32'hDEAD_BEEF);
        send_pixel(9'd10, 32'hDEAD_BEEF);
        send_pixel(9'd470, 32'hDEAD_BEEF);
        send_pixel(9'd480, 32'hDEAD_BEEF);
        set_reg(REG_BORDER_MODE, 32'(BORDER_BLEND1));
        send_pixel(9'd475, 32'h7F00_FF80);
        // blend without a top band leaves even the bottom band alone
        set_reg(REG_BORDER_TOP, 32'd0);
        set_reg(REG_BORDER_MODE, 32'(BORDER_BLEND2));
        send_pixel(9'd475, 32'h7F00_FF80);
        set_reg(REG_BORDER_MODE, 32'(BORDER_FILL));
        set_reg(REG_BORDER_BOTTOM, 32'd500);
        send_pixel(9'd479, 32'h0102_0304);
        settings_used++;
    endtask

    task automatic randomize_settings(int phase);
        logic [31:0] v;
        if (phase == 0)
        begin
            // every register at its top value
            set_reg(REG_FADE_MODE, with_noise(32'd7, 3));
            set_reg(REG_FADE_ALPHA, with_noise(32'd255, 8));
            set_reg(REG_FADE_FROM_COLOUR, with_noise(32'hFF_FFFF, 24));
            set_reg(REG_FADE_TO_COLOUR, with_noise(32'hFF_FFFF, 24));
            set_reg(REG_BORDER_MODE, with_noise(32'(BORDER_OFF), 2));
            set_reg(REG_BORDER_COLOUR, 32'hFFFF_FFFF);
            set_reg(REG_BORDER_TOP, with_noise(32'd511, ROW_W));
            set_reg(REG_BORDER_BOTTOM, with_noise(32'd511, ROW_W));
        end
        else if (phase == 1)
        begin
            // every register at zero
            set_reg(REG_FADE_MODE, 32'(FADE_NONE));
            set_reg(REG_FADE_ALPHA, 32'd0);
            set_reg(REG_FADE_FROM_COLOUR, 32'd0);
            set_reg(REG_FADE_TO_COLOUR, 32'd0);
            set_reg(REG_BORDER_MODE, 32'(BORDER_FILL));
            set_reg(REG_BORDER_COLOUR, 32'd0);
            set_reg(REG_BORDER_TOP, 32'd0);
            set_reg(REG_BORDER_BOTTOM, 32'd0);
        end
        else
        begin
            v = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 7) : $urandom_range(1, 4);
            set_reg(REG_FADE_MODE, with_noise(v, 3));
            case ($urandom_range(0, 9))
                0:       v = 0;
                1:       v = 255;
                2:       v = 1;
                default: v = $urandom_range(0, 255);
            endcase
            set_reg(REG_FADE_ALPHA, with_noise(v, 8));
            set_reg(REG_FADE_FROM_COLOUR, with_noise($urandom() & 32'hFF_FFFF, 24));
            set_reg(REG_FADE_TO_COLOUR, with_noise($urandom() & 32'hFF_FFFF, 24));
            set_reg(REG_BORDER_MODE, with_noise($urandom_range(0, 3), 2));
            v = $urandom();
            case ($urandom_range(0, 3))
                0:       v[31:24] = 8'h00;
                1:       v[31:24] = 8'hFF;
                default: ;
            endcase
            set_reg(REG_BORDER_COLOUR, v);
            v = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 240);
            set_reg(REG_BORDER_TOP, with_noise(v, ROW_W));
            case ($urandom_range(0, 9))
                0, 1:    v = SCREEN_ROWS;
                2:       v = $urandom_range(SCREEN_ROWS, 511);
                default: v = $urandom_range(200, SCREEN_ROWS - 1);
            endcase
            set_reg(REG_BORDER_BOTTOM, with_noise(v, ROW_W));
        end
        settings_used++;
    endtask

    task automatic test_random_traffic();
        int phase;
        int n;
        for (phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            randomize_settings(phase);
            // one phase runs flat out on both sides
            gaps_enabled = (phase != 7);
            for (n = 0; n < PHASE_PIXELS; n++)
            begin
                if (phase % 3 == 0 && n == PHASE_PIXELS / 2)
                    wait_idle(0);
                send_pixel(pick_row(), $urandom());
            end
        end
        gaps_enabled = 1'b1;
    endtask

    initial
    begin
        rst_n                = 1'b0;
        cfg_we               = 1'b0;
        cfg_index            = '0;
        cfg_data             = '0;
        pix_in_bus.valid     = 1'b0;
        pix_in_bus.row       = '0;
        pix_in_bus.pixel_in  = '0;
        gaps_enabled         = 1'b1;
        pixels_sent          = 0;
        settings_used        = 1;
        cur_fade_mode        = FADE_NONE;
        cur_fade_alpha       = '0;
        cur_fade_from        = '0;
        cur_fade_to          = '0;
        cur_border_mode      = BORDER_FILL;
        cur_border_colour    = '0;
        cur_border_top       = '0;
        cur_border_bottom    = BORDER_BOTTOM_RST;

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_reset_state();
        test_fade_modes();
        test_border_bands();
        test_random_traffic();

        wait_idle(10);
        $display("%0d pixels sent, %0d checked, over %0d register settings",
                 pixels_sent, pixels_checked, settings_used);
        $display("fade modes 0-7, border fill/blend/off, band edges and off-screen rows");
        if (errors == 0)
            $display("[pixel_fade_and_border_effects] OK");
        else
            $display("[pixel_fade_and_border_effects] ERROR");
        $finish;
    end

endmodule
